// ===== src/point_in_prism_region_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Point-in-prism region unit: assertion macros
// Shared concurrent assertion forms for the point-in-prism region unit.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_PRISM_REGION_UNIT_DEFINES_SVH
`define POINT_IN_PRISM_REGION_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PIPS_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define PIPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pips_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-prism region package
// Shape and register codes, flag groups passed between stages, and the
// sign/square decision used for the sqrt(3) edge tests.
// ----------------------------------------------------------------------------
package pips_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int NUM_STAGES      = 7;

  typedef enum logic [1:0] {
    SHAPE_BOX   = 2'd0,
    SHAPE_HEX   = 2'd1,
    SHAPE_RHOMB = 2'd2,
    SHAPE_CYL   = 2'd3
  } shape_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE_MODE = 3'd0,
    REG_CENTER_X   = 3'd1,
    REG_CENTER_Y   = 3'd2,
    REG_CENTER_Z   = 3'd3,
    REG_EXTENT_X   = 3'd4,
    REG_EXTENT_Y   = 3'd5,
    REG_EXTENT_Z   = 3'd6
  } cfg_reg_e;

  // Sign and bound flags worked out from the offsets
  typedef struct packed {
    logic box_in;      // strict box bounds met on all axes
    logic z_out;       // beyond the inclusive height bounds
    logic dx_neg;
    logic dy_neg;
    logic dy_zero;
    logic hx_a_neg;    // sign of the sector-folded dy
    logic dp_neg;      // dx + R
    logic dp_zero;
    logic dm_neg;      // dx - R
    logic dm_zero;
    logic rb_b_neg;    // R - dx negative
    logic mid;         // -R <= 2dx <= R
    logic dx_gt_half;  // 2dx > R
  } geo_flags_t;

  // Results of the wide square compares
  typedef struct packed {
    logic hx_out_r;    // dx^2+dy^2 > R^2
    logic hx_in_r;     // 4(dx^2+dy^2) < 3R^2
    logic dy_le;       // 4dy^2 <= 3R^2
    logic lt_p;        // dy^2 < 3(dx+R)^2
    logic gt_p;
    logic lt_m;        // dy^2 < 3(dx-R)^2
    logic gt_m;
    logic dy_lt_3dx;   // dy^2 < 3dx^2
    logic cyl_in;      // dx^2+dy^2 < R^2
  } cmp_flags_t;

  // Sign of a - sqrt3*b is positive
  function automatic logic root3_gt(logic a_neg, logic a_zero, logic b_neg, logic b_zero,
                                    logic sq_lt, logic sq_gt);
    logic a_pos;
    logic b_pos;
    a_pos = !a_neg && !a_zero;
    b_pos = !b_neg && !b_zero;
    return (!a_neg && (b_neg || b_zero) && !(a_zero && b_zero)) ||
           (a_pos && b_pos && sq_gt) || (a_neg && b_neg && sq_lt);
  endfunction

  // Sign of a - sqrt3*b is negative
  function automatic logic root3_lt(logic a_neg, logic a_zero, logic b_neg, logic b_zero,
                                    logic sq_lt, logic sq_gt);
    logic a_pos;
    logic b_pos;
    a_pos = !a_neg && !a_zero;
    b_pos = !b_neg && !b_zero;
    return ((a_neg || a_zero) && !b_neg && !(a_zero && b_zero)) ||
           (a_pos && b_pos && sq_lt) || (a_neg && b_neg && sq_gt);
  endfunction

endpackage

// ===== src/pips_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-prism front end
// Two stages: offset from the centre, then bound tests, sign flags and the
// magnitudes handed to the squarers.
// ----------------------------------------------------------------------------
module pips_front #(
  parameter int COORD_WIDTH = pips_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic [1:0]                    en_i,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  logic signed [COORD_WIDTH-1:0] center_x_i,
  input  logic signed [COORD_WIDTH-1:0] center_y_i,
  input  logic signed [COORD_WIDTH-1:0] center_z_i,
  input  logic [COORD_WIDTH-2:0]        extent_x_i,
  input  logic [COORD_WIDTH-2:0]        extent_y_i,
  input  logic [COORD_WIDTH-2:0]        extent_z_i,
  output logic [COORD_WIDTH:0]          mag_dx_o,
  output logic [COORD_WIDTH:0]          mag_dy_o,
  output logic [COORD_WIDTH:0]          mag_dp_o,
  output logic [COORD_WIDTH:0]          mag_dm_o,
  output pips_pkg::geo_flags_t          geo_o
);

  localparam int DW = COORD_WIDTH + 1;  // offset
  localparam int EW = COORD_WIDTH + 2;  // doubled offset, dx +/- R
  localparam int MW = COORD_WIDTH + 1;  // magnitudes

  logic signed [DW-1:0] dx_d, dy_d, dz_d;
  logic signed [DW-1:0] dx_q, dy_q, dz_q;

  logic signed [EW-1:0] dx2, dy2, dz2, dxe, rx, ry, rz, dp, dm, neg_dp, neg_dm;
  logic signed [DW-1:0] neg_dx, neg_dy;
  logic                 flip;

  logic [MW-1:0]        mag_dx_d, mag_dy_d, mag_dp_d, mag_dm_d;
  logic [MW-1:0]        mag_dx_q, mag_dy_q, mag_dp_q, mag_dm_q;
  pips_pkg::geo_flags_t geo_d, geo_q;

  // Stage 1: offset from the centre
  assign dx_d = {pos_x_i[COORD_WIDTH-1], pos_x_i} - {center_x_i[COORD_WIDTH-1], center_x_i};
  assign dy_d = {pos_y_i[COORD_WIDTH-1], pos_y_i} - {center_y_i[COORD_WIDTH-1], center_y_i};
  assign dz_d = {pos_z_i[COORD_WIDTH-1], pos_z_i} - {center_z_i[COORD_WIDTH-1], center_z_i};

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      dz_q <= dz_d;
    end
  end

  // Stage 2: bounds, signs and magnitudes
  always_comb begin
    dx2    = {dx_q, 1'b0};
    dy2    = {dy_q, 1'b0};
    dz2    = {dz_q, 1'b0};
    dxe    = {dx_q[DW-1], dx_q};
    rx     = {3'b000, extent_x_i};
    ry     = {3'b000, extent_y_i};
    rz     = {3'b000, extent_z_i};
    dp     = dxe + rx;
    dm     = dxe - rx;
    neg_dp = -dp;
    neg_dm = -dm;
    neg_dx = -dx_q;
    neg_dy = -dy_q;

    geo_d.box_in = (dx2 > -rx) && (dx2 < rx) && (dy2 > -ry) && (dy2 < ry) &&
                   (dz2 > -rz) && (dz2 < rz);
    geo_d.z_out  = (dz2 > rz) || (dz2 < -rz);
    geo_d.dx_neg  = dx_q[DW-1];
    geo_d.dy_neg  = dy_q[DW-1];
    geo_d.dy_zero = (dy_q == '0);
    // fold dy into the sector of the hexagon edge under test
    flip = (!dy_q[DW-1] && !dx_q[DW-1] && (dx_q != '0)) || (dy_q[DW-1] && dx_q[DW-1]);
    geo_d.hx_a_neg   = flip ? (!dy_q[DW-1] && (dy_q != '0)) : dy_q[DW-1];
    geo_d.dp_neg     = dp[EW-1];
    geo_d.dp_zero    = (dp == '0);
    geo_d.dm_neg     = dm[EW-1];
    geo_d.dm_zero    = (dm == '0);
    geo_d.rb_b_neg   = !dm[EW-1] && (dm != '0);
    geo_d.mid        = (dx2 <= rx) && (dx2 >= -rx);
    geo_d.dx_gt_half = (dx2 > rx);

    mag_dx_d = dx_q[DW-1] ? neg_dx : dx_q;
    mag_dy_d = dy_q[DW-1] ? neg_dy : dy_q;
    mag_dp_d = dp[EW-1] ? neg_dp[MW-1:0] : dp[MW-1:0];
    mag_dm_d = dm[EW-1] ? neg_dm[MW-1:0] : dm[MW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mag_dx_q <= mag_dx_d;
      mag_dy_q <= mag_dy_d;
      mag_dp_q <= mag_dp_d;
      mag_dm_q <= mag_dm_d;
      geo_q    <= geo_d;
    end
  end

  assign mag_dx_o = mag_dx_q;
  assign mag_dy_o = mag_dy_q;
  assign mag_dp_o = mag_dp_q;
  assign mag_dm_o = mag_dm_q;
  assign geo_o    = geo_q;

endmodule

// ===== src/pips_sqr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-prism squarer
// Two-stage unsigned squarer: half-width partial products, then their sum.
// ----------------------------------------------------------------------------
module pips_sqr #(
  parameter int OP_WIDTH = pips_pkg::COORD_WIDTH_DEF + 1
) (
  input  logic                  clk_i,
  input  logic [1:0]            en_i,
  input  logic [OP_WIDTH-1:0]   op_i,
  output logic [2*OP_WIDTH-1:0] sq_o
);

  localparam int LW = (OP_WIDTH + 1) / 2;
  localparam int HW = OP_WIDTH - LW;
  localparam int PW = 2 * OP_WIDTH;

  logic [LW-1:0]      lo;
  logic [HW-1:0]      hi;
  logic [2*LW-1:0]    pll_q;
  logic [HW+LW-1:0]   phl_q;
  logic [2*HW-1:0]    phh_q;
  logic [PW-1:0]      sq_d, sq_q;

  assign lo = op_i[LW-1:0];
  assign hi = op_i[OP_WIDTH-1:LW];

  // Stage A: partial products
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pll_q <= lo * lo;
      phl_q <= hi * lo;
      phh_q <= hi * hi;
    end
  end

  // Stage B: hi^2 << 2L + 2*hi*lo << L + lo^2
  assign sq_d = (PW'(phh_q) << (2 * LW)) + (PW'(phl_q) << (LW + 1)) + PW'(pll_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

// ===== src/pips_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-prism square compare
// Two stages: scaled sums of the squares, then the wide magnitude compares.
// The flags from the front end ride along.
// ----------------------------------------------------------------------------
module pips_cmp #(
  parameter int SQ_WIDTH = 2 * (pips_pkg::COORD_WIDTH_DEF + 1)
) (
  input  logic                  clk_i,
  input  logic [1:0]            en_i,
  input  logic [SQ_WIDTH-1:0]   sq_dx_i,
  input  logic [SQ_WIDTH-1:0]   sq_dy_i,
  input  logic [SQ_WIDTH-1:0]   sq_r_i,
  input  logic [SQ_WIDTH-1:0]   sq_dp_i,
  input  logic [SQ_WIDTH-1:0]   sq_dm_i,
  input  pips_pkg::geo_flags_t  geo_i,
  output pips_pkg::geo_flags_t  geo_o,
  output pips_pkg::cmp_flags_t  cmp_o
);

  localparam int SW = SQ_WIDTH + 3;

  logic [SW-1:0] r2_d, rr_d, rr3_d, dy2_d, dx3_d, dp3_d, dm3_d;
  logic [SW-1:0] r2_q, rr_q, rr3_q, dy2_q, dx3_q, dp3_q, dm3_q;
  pips_pkg::geo_flags_t geo_s5_q, geo_s6_q;
  pips_pkg::cmp_flags_t cmp_d, cmp_q;

  // Stage A: radius sum and products by three
  always_comb begin
    r2_d  = SW'(sq_dx_i) + SW'(sq_dy_i);
    rr_d  = SW'(sq_r_i);
    rr3_d = SW'(sq_r_i) + (SW'(sq_r_i) << 1);
    dy2_d = SW'(sq_dy_i);
    dx3_d = SW'(sq_dx_i) + (SW'(sq_dx_i) << 1);
    dp3_d = SW'(sq_dp_i) + (SW'(sq_dp_i) << 1);
    dm3_d = SW'(sq_dm_i) + (SW'(sq_dm_i) << 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r2_q     <= r2_d;
      rr_q     <= rr_d;
      rr3_q    <= rr3_d;
      dy2_q    <= dy2_d;
      dx3_q    <= dx3_d;
      dp3_q    <= dp3_d;
      dm3_q    <= dm3_d;
      geo_s5_q <= geo_i;
    end
  end

  // Stage B: compares
  always_comb begin
    cmp_d.hx_out_r  = (r2_q > rr_q);
    cmp_d.hx_in_r   = ((r2_q << 2) < rr3_q);
    cmp_d.dy_le     = ((dy2_q << 2) <= rr3_q);
    cmp_d.lt_p      = (dy2_q < dp3_q);
    cmp_d.gt_p      = (dy2_q > dp3_q);
    cmp_d.lt_m      = (dy2_q < dm3_q);
    cmp_d.gt_m      = (dy2_q > dm3_q);
    cmp_d.dy_lt_3dx = (dy2_q < dx3_q);
    cmp_d.cyl_in    = (r2_q < rr_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      cmp_q    <= cmp_d;
      geo_s6_q <= geo_s5_q;
    end
  end

  assign cmp_o = cmp_q;
  assign geo_o = geo_s6_q;

endmodule

// ===== src/point_in_prism_region_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-prism region unit
// Tests a 3-D point against a box, hexagonal prism, rhombic prism or
// cylinder centred on a configured point.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_stall_o   pos_x_i, pos_y_i, pos_z_i
//   out      source     out_valid_o/out_stall_i inside_res_o
//   cfg      sink       cfg_we_i                cfg_idx_i, cfg_data_i
//
// One word per cycle in and out while out_stall_i is low; a word passes through
// offset, bounds, two squarer stages, two compare stages and the decision register.
// The squarers (half-width partial products) set the stage depth.
// Reset clears the valid bits and the configuration registers.
// Each stage holds while the next is full and blocked; bubbles close up,
// so a new word is taken while a finished result waits.
// ----------------------------------------------------------------------------
`include "point_in_prism_region_unit_defines.svh"

module point_in_prism_region_unit #(
  parameter int COORD_WIDTH = pips_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]  pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]  pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]  pos_z_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           inside_res_o,
  input  logic                           cfg_we_i,
  input  logic [pips_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]         cfg_data_i
);

  localparam int MW = COORD_WIDTH + 1;
  localparam int PW = 2 * MW;
  localparam int NS = pips_pkg::NUM_STAGES;

  pips_pkg::shape_e               shape_q;
  logic signed [COORD_WIDTH-1:0]  center_x_q, center_y_q, center_z_q;
  logic [COORD_WIDTH-2:0]         extent_x_q, extent_y_q, extent_z_q;

  logic [NS-1:0] valid_q;
  logic [NS:0]   adv;

  logic [MW-1:0]        mag_dx, mag_dy, mag_dp, mag_dm;
  logic [PW-1:0]        sq_dx, sq_dy, sq_r, sq_dp, sq_dm;
  pips_pkg::geo_flags_t geo_s2, geo_s3_q, geo_s4_q, geo_s6;
  pips_pkg::cmp_flags_t cmp_s6;

  logic box_in, hex_in, rhomb_in, cyl_in;
  logic inside_d, inside_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q    <= pips_pkg::SHAPE_BOX;
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      extent_x_q <= '0;
      extent_y_q <= '0;
      extent_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (pips_pkg::cfg_reg_e'(cfg_idx_i))
        pips_pkg::REG_SHAPE_MODE: shape_q    <= pips_pkg::shape_e'(cfg_data_i[1:0]);
        pips_pkg::REG_CENTER_X:   center_x_q <= cfg_data_i;
        pips_pkg::REG_CENTER_Y:   center_y_q <= cfg_data_i;
        pips_pkg::REG_CENTER_Z:   center_z_q <= cfg_data_i;
        pips_pkg::REG_EXTENT_X:   extent_x_q <= cfg_data_i[COORD_WIDTH-2:0];
        pips_pkg::REG_EXTENT_Y:   extent_y_q <= cfg_data_i[COORD_WIDTH-2:0];
        pips_pkg::REG_EXTENT_Z:   extent_z_q <= cfg_data_i[COORD_WIDTH-2:0];
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    adv[NS] = !out_stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = valid_q[NS-1];

  // Stages 1-2: offsets, bounds and magnitudes
  pips_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .en_i       (adv[1:0]),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .center_z_i (center_z_q),
    .extent_x_i (extent_x_q),
    .extent_y_i (extent_y_q),
    .extent_z_i (extent_z_q),
    .mag_dx_o   (mag_dx),
    .mag_dy_o   (mag_dy),
    .mag_dp_o   (mag_dp),
    .mag_dm_o   (mag_dm),
    .geo_o      (geo_s2)
  );

  // Stages 3-4: squares
  pips_sqr #(.OP_WIDTH(MW)) u_sqr_dx (
    .clk_i(clk_i), .en_i(adv[3:2]), .op_i(mag_dx), .sq_o(sq_dx)
  );
  pips_sqr #(.OP_WIDTH(MW)) u_sqr_dy (
    .clk_i(clk_i), .en_i(adv[3:2]), .op_i(mag_dy), .sq_o(sq_dy)
  );
  pips_sqr #(.OP_WIDTH(MW)) u_sqr_r (
    .clk_i(clk_i), .en_i(adv[3:2]), .op_i({2'b00, extent_x_q}), .sq_o(sq_r)
  );
  pips_sqr #(.OP_WIDTH(MW)) u_sqr_dp (
    .clk_i(clk_i), .en_i(adv[3:2]), .op_i(mag_dp), .sq_o(sq_dp)
  );
  pips_sqr #(.OP_WIDTH(MW)) u_sqr_dm (
    .clk_i(clk_i), .en_i(adv[3:2]), .op_i(mag_dm), .sq_o(sq_dm)
  );

  // Carry the flags alongside the squarers
  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      geo_s3_q <= geo_s2;
    end
    if (adv[3]) begin
      geo_s4_q <= geo_s3_q;
    end
  end

  // Stages 5-6: scaled sums and compares
  pips_cmp #(
    .SQ_WIDTH(PW)
  ) u_cmp (
    .clk_i   (clk_i),
    .en_i    (adv[5:4]),
    .sq_dx_i (sq_dx),
    .sq_dy_i (sq_dy),
    .sq_r_i  (sq_r),
    .sq_dp_i (sq_dp),
    .sq_dm_i (sq_dm),
    .geo_i   (geo_s4_q),
    .geo_o   (geo_s6),
    .cmp_o   (cmp_s6)
  );

  // Stage 7: per-shape decision
  always_comb begin
    box_in = geo_s6.box_in;
    cyl_in = !geo_s6.z_out && cmp_s6.cyl_in;

    priority if (geo_s6.z_out || cmp_s6.hx_out_r) begin
      hex_in = 1'b0;
    end else if (cmp_s6.hx_in_r) begin
      hex_in = 1'b1;
    end else if (geo_s6.mid) begin
      hex_in = cmp_s6.dy_le;
    end else begin
      // folded dy between the two slanted edges of the sector
      hex_in = !pips_pkg::root3_gt(geo_s6.hx_a_neg, geo_s6.dy_zero, geo_s6.dp_neg,
                                   geo_s6.dp_zero, cmp_s6.lt_p, cmp_s6.gt_p) &&
               !pips_pkg::root3_lt(geo_s6.hx_a_neg, geo_s6.dy_zero, geo_s6.dm_neg,
                                   geo_s6.dm_zero, cmp_s6.lt_m, cmp_s6.gt_m);
    end

    priority if (geo_s6.z_out || geo_s6.dy_neg || !cmp_s6.dy_le) begin
      rhomb_in = 1'b0;
    end else if (geo_s6.dx_neg && cmp_s6.dy_lt_3dx) begin
      rhomb_in = 1'b0;
    end else if (geo_s6.dx_gt_half &&
                 pips_pkg::root3_gt(1'b0, geo_s6.dy_zero, geo_s6.rb_b_neg,
                                    geo_s6.dm_zero, cmp_s6.lt_m, cmp_s6.gt_m)) begin
      rhomb_in = 1'b0;
    end else begin
      rhomb_in = 1'b1;
    end
  end

  always_comb begin
    unique case (shape_q)
      pips_pkg::SHAPE_BOX:   inside_d = box_in;
      pips_pkg::SHAPE_HEX:   inside_d = hex_in;
      pips_pkg::SHAPE_RHOMB: inside_d = rhomb_in;
      pips_pkg::SHAPE_CYL:   inside_d = cyl_in;
      default:               inside_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[NS-1]) begin
      inside_q <= inside_d;
    end
  end

  assign inside_res_o = inside_q;

  // Pipeline control checks
  `PIPS_ASSERT_HOLDS(a_stall_only_when_full, clk_i, rst_ni, in_stall_o, (&valid_q) && out_stall_i, "input stalled with a free stage")
  `PIPS_ASSERT_HOLDS(a_drain_frees_input, clk_i, rst_ni, !out_stall_i, !in_stall_o, "input stalled while output drains")
  `PIPS_ASSERT_NEXT(a_accept_lands, clk_i, rst_ni, in_valid_i && !in_stall_o, valid_q[0], "accepted word lost at stage 1")
  `PIPS_ASSERT_NEXT(a_blocked_stage_keeps, clk_i, rst_ni, valid_q[NS-2] && !adv[NS-2], valid_q[NS-2], "blocked stage dropped its word")

endmodule
